// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the crusher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is high.
`define SBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on every rising edge, reset included.
`define SBC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// File: rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and constants shared by the stereo bit crusher files.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int CODE_W      = 8;
   localparam int GAIN_W      = 12;
   localparam int COUNT_W     = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 29;
   localparam int MUL_B_W = 14;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Divider widths: dividend magnitude, divisor, signed quotient
   localparam int DIV_NUM_W  = 23;
   localparam int DIV_DEN_W  = COUNT_W;
   localparam int DIV_QUOT_W = SAMPLE_W;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_MASK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_MASK   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_GAIN    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_GAIN   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONO_OUTPUT = 3'd7;

   localparam logic [GAIN_W-1:0]         GAIN_ONE      = 12'd1024;
   localparam logic signed [SAMPLE_W-1:0] SILENCE_LIMIT = 16'sd327;
   localparam logic [COUNT_W-1:0]         COUNT_MAX     = 24'hFFFFFF;
   localparam logic [COUNT_W-1:0]         FADE_START    = 24'd128;
   localparam logic [CODE_W-1:0]          ALL_BITS      = 8'hFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_MUL,
      ST_CODE,
      ST_BLEND_MUL,
      ST_DRY_MUL,
      ST_SUM,
      ST_POST_MUL,
      ST_CLIP,
      ST_MIX,
      ST_DIV_LEFT,
      ST_DIV_RIGHT,
      ST_DIV_MONO,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [DIV_NUM_W-1:0] magnitude;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [DIV_QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/core/sbc_req_if.sv
// ----------------------------------------------------------------------------
// sbc_req_if
// Request channel: one stereo or mono sample pair per handshake.
// ----------------------------------------------------------------------------
interface sbc_req_if;
   import sbc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_left;
   logic signed [SAMPLE_W-1:0] sample_right;
   logic                       right_present;

   modport source (output valid, output sample_left, output sample_right,
                   output right_present, input ready);
   modport sink   (input valid, input sample_left, input sample_right,
                   input right_present, output ready);
endinterface

// File: rtl/core/sbc_rsp_if.sv
// ----------------------------------------------------------------------------
// sbc_rsp_if
// Response channel: processed sample pair and the crushed code.
// ----------------------------------------------------------------------------
interface sbc_rsp_if;
   import sbc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;
   logic [CODE_W-1:0]          crushed_code;

   modport source (output valid, output out_left, output out_right,
                   output crushed_code, input ready);
   modport sink   (input valid, input out_left, input out_right,
                   input crushed_code, output ready);
endinterface

// File: rtl/core/stereo_bit_crusher.sv
// Requests are taken one at a time: a new one is accepted only after the
//   last result has moved into the response register. The shared multiplier
//   (seven steps per side) and the one-bit-a-cycle divider set the pace.
// Reset (synchronous, active high): registers take their default values,
//   the silence count clears and no response is pending.
// ----------------------------------------------------------------------------
// stereo_bit_crusher
// 8-bit bit crusher for a stereo or mono sample pair, with blend, post gain,
// silence fade and optional mono mix, run on one multiplier and one divider.
// ----------------------------------------------------------------------------
module stereo_bit_crusher (
   input  logic                                clock,
   input  logic                                reset,
   sbc_req_if.sink                             req_chan,
   sbc_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [sbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sbc_pkg::*;

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   logic              signed_mode_ff;
   logic              bypass_ff;
   logic [CODE_W-1:0] invert_mask_ff;
   logic [CODE_W-1:0] zero_mask_ff;
   logic [GAIN_W-1:0] pre_gain_ff;
   logic [GAIN_W-1:0] post_gain_ff;
   logic [GAIN_W-1:0] blend_ff;
   logic              mono_output_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
         bypass_ff      <= 1'b0;
         invert_mask_ff <= '0;
         zero_mask_ff   <= '0;
         pre_gain_ff    <= GAIN_ONE;
         post_gain_ff   <= GAIN_ONE;
         blend_ff       <= GAIN_ONE;
         mono_output_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            CSR_BYPASS:      bypass_ff      <= csr_wdata[0];
            CSR_INVERT_MASK: invert_mask_ff <= csr_wdata[CODE_W-1:0];
            CSR_ZERO_MASK:   zero_mask_ff   <= csr_wdata[CODE_W-1:0];
            CSR_PRE_GAIN:    pre_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_POST_GAIN:   post_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_BLEND:       blend_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_MONO_OUTPUT: mono_output_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer and datapath registers
   // ------------------------------------------------------------------
   seq_state_type              state_ff, state_in;
   logic                       side_ff, side_in;         // 0 left, 1 right
   logic signed [SAMPLE_W-1:0] xl_ff, xl_in;
   logic signed [SAMPLE_W-1:0] xr_ff, xr_in;
   logic [COUNT_W-1:0]         mute_count_ff, mute_count_in;
   logic [CODE_W-1:0]          code_l_ff, code_l_in;
   logic [CODE_W-1:0]          code_r_ff, code_r_in;
   logic signed [SAMPLE_W-1:0] crush_val_ff, crush_val_in;
   logic signed [MUL_A_W-1:0]  num_ff, num_in;
   logic signed [SAMPLE_W-1:0] side_l_ff, side_l_in;
   logic signed [SAMPLE_W-1:0] side_r_ff, side_r_in;
   logic signed [SAMPLE_W-1:0] res_l_ff, res_l_in;
   logic signed [SAMPLE_W-1:0] res_r_ff, res_r_in;
   logic [CODE_W-1:0]          res_code_ff, res_code_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff;
   logic signed [SAMPLE_W-1:0] rsp_right_ff;
   logic [CODE_W-1:0]          rsp_code_ff;
   logic                       rsp_load;

   // Shared units
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] product;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   sbc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   sbc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------
   // Quantiser: pre-gain product times 255, scaled down by 2^26
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] x_cur;
   logic signed [MUL_A_W-1:0]  pg_prod;
   logic signed [MUL_A_W-1:0]  ob_bias;
   logic signed [36:0]         sc_t, sc_adj, ob_t;
   logic signed [10:0]         q_s, q_o;
   logic [CODE_W-1:0]          raw_code, code_new;
   logic signed [SAMPLE_W-1:0] crush_new;
   logic signed [MUL_B_W-1:0]  dry_w;

   assign x_cur   = side_ff ? xr_ff : xl_ff;
   assign pg_prod = product[MUL_A_W-1:0];
   assign dry_w   = 14'sd1024 - $signed({2'b00, blend_ff});

   always_comb begin
      // times 255 as times 256 minus one
      sc_t    = $signed({pg_prod, 8'b0}) - $signed({{8{pg_prod[MUL_A_W-1]}}, pg_prod});
      // signed code truncates towards zero
      sc_adj  = sc_t[36] ? sc_t + 37'sd67108863 : sc_t;
      q_s     = sc_adj[36:26];
      // offset code: add half scale first; floor is safe as negatives clamp
      ob_bias = pg_prod + 29'sd33554432;
      ob_t    = $signed({ob_bias, 8'b0}) - $signed({{8{ob_bias[MUL_A_W-1]}}, ob_bias});
      q_o     = ob_t[36:26];
      if (signed_mode_ff) begin
         if (q_s > 11'sd127) begin
            raw_code = 8'h7F;
         end else if (q_s < -11'sd128) begin
            raw_code = 8'h80;
         end else begin
            raw_code = q_s[CODE_W-1:0];
         end
      end else begin
         if (q_o[10]) begin
            raw_code = 8'h00;
         end else if (q_o > 11'sd255) begin
            raw_code = 8'hFF;
         end else begin
            raw_code = q_o[CODE_W-1:0];
         end
      end
      code_new = (raw_code ^ invert_mask_ff) & ~zero_mask_ff;
      // back to Q1.15: code * 256, offset code recentred on 128
      if (signed_mode_ff) begin
         crush_new = $signed({code_new, 8'b0});
      end else begin
         crush_new = $signed({~code_new[CODE_W-1], code_new[CODE_W-2:0], 8'b0});
      end
   end

   // ------------------------------------------------------------------
   // Post-gain scaling: truncate towards zero by 2^20 and clip to Q1.15
   // ------------------------------------------------------------------
   logic signed [MUL_P_W-1:0] post_adj;
   logic signed [22:0]        post_sh;
   logic signed [SAMPLE_W-1:0] clip_new;

   always_comb begin
      post_adj = product[MUL_P_W-1] ? product + 43'sd1048575 : product;
      post_sh  = post_adj[MUL_P_W-1:20];
      if (post_sh > 23'sd32767) begin
         clip_new = 16'sh7FFF;
      end else if (post_sh < -23'sd32768) begin
         clip_new = 16'sh8000;
      end else begin
         clip_new = post_sh[SAMPLE_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Mix helpers
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W:0] mix_sum;
   logic signed [SAMPLE_W:0] mix_half;
   logic [SAMPLE_W:0]        mix_mag;
   logic [SAMPLE_W-1:0]      left_mag, right_mag;
   logic                     fade;
   logic signed [SAMPLE_W-1:0] req_right;
   logic                     req_silent;

   always_comb begin
      mix_sum   = {side_l_ff[SAMPLE_W-1], side_l_ff} + {side_r_ff[SAMPLE_W-1], side_r_ff};
      // halve towards zero: add one to negative sums before the shift
      mix_half  = mix_sum + $signed({{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]});
      mix_mag   = mix_sum[SAMPLE_W] ? (SAMPLE_W+1)'(-mix_sum) : mix_sum;
      left_mag  = side_l_ff[SAMPLE_W-1] ? SAMPLE_W'(-side_l_ff) : side_l_ff;
      right_mag = side_r_ff[SAMPLE_W-1] ? SAMPLE_W'(-side_r_ff) : side_r_ff;
      fade      = (mute_count_ff >= FADE_START);
      req_right = req_chan.right_present ? req_chan.sample_right : req_chan.sample_left;
      req_silent = (req_chan.sample_left >= -SILENCE_LIMIT &&
                    req_chan.sample_left <= SILENCE_LIMIT &&
                    req_right >= -SILENCE_LIMIT &&
                    req_right <= SILENCE_LIMIT) ||
                   (zero_mask_ff == ALL_BITS);
   end

   // ------------------------------------------------------------------
   // Sequencer: next state, unit operands and datapath updates
   // ------------------------------------------------------------------
   assign rsp_load       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      side_in       = side_ff;
      xl_in         = xl_ff;
      xr_in         = xr_ff;
      mute_count_in = mute_count_ff;
      code_l_in     = code_l_ff;
      code_r_in     = code_r_ff;
      crush_val_in  = crush_val_ff;
      num_in        = num_ff;
      side_l_in     = side_l_ff;
      side_r_in     = side_r_ff;
      res_l_in      = res_l_ff;
      res_r_in      = res_r_ff;
      res_code_in   = res_code_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req           = '0;
      div_req.divisor   = mute_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               xl_in   = req_chan.sample_left;
               xr_in   = req_right;
               side_in = 1'b0;
               if (bypass_ff) begin
                  // pass through; the silence count stays as it is
                  res_l_in    = req_chan.sample_left;
                  res_r_in    = mono_output_ff ? '0 : req_right;
                  res_code_in = '0;
                  state_in    = ST_OUT;
               end else begin
                  if (req_silent) begin
                     if (mute_count_ff != COUNT_MAX) begin
                        mute_count_in = mute_count_ff + 1'b1;
                     end
                  end else begin
                     mute_count_in = '0;
                  end
                  state_in = ST_PRE_MUL;
               end
            end
         end
         ST_PRE_MUL: begin
            mul_a    = MUL_A_W'(x_cur);
            mul_b    = $signed({2'b00, pre_gain_ff});
            state_in = ST_CODE;
         end
         ST_CODE: begin
            if (side_ff) begin
               code_r_in = code_new;
            end else begin
               code_l_in = code_new;
            end
            crush_val_in = crush_new;
            state_in     = ST_BLEND_MUL;
         end
         ST_BLEND_MUL: begin
            mul_a    = MUL_A_W'(crush_val_ff);
            mul_b    = $signed({2'b00, blend_ff});
            state_in = ST_DRY_MUL;
         end
         ST_DRY_MUL: begin
            // wet term arrives while the dry term is issued
            mul_a    = MUL_A_W'(x_cur);
            mul_b    = dry_w;
            num_in   = pg_prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            num_in   = num_ff + pg_prod;
            state_in = ST_POST_MUL;
         end
         ST_POST_MUL: begin
            mul_a    = num_ff;
            mul_b    = $signed({2'b00, post_gain_ff});
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            if (side_ff) begin
               side_r_in = clip_new;
               state_in  = ST_MIX;
            end else begin
               side_l_in = clip_new;
               side_in   = 1'b1;
               state_in  = ST_PRE_MUL;
            end
         end
         ST_MIX: begin
            // left code, unless the left sample is exactly zero
            res_code_in = (xl_ff == '0) ? code_r_ff : code_l_ff;
            if (mono_output_ff) begin
               res_r_in = '0;
               if (fade) begin
                  div_req.start     = 1'b1;
                  div_req.neg       = mix_sum[SAMPLE_W];
                  div_req.magnitude = {mix_mag, 6'b0};
                  state_in          = ST_DIV_MONO;
               end else begin
                  res_l_in = mix_half[SAMPLE_W:1];
                  state_in = ST_OUT;
               end
            end else begin
               if (fade) begin
                  div_req.start     = 1'b1;
                  div_req.neg       = side_l_ff[SAMPLE_W-1];
                  div_req.magnitude = {left_mag, 7'b0};
                  state_in          = ST_DIV_LEFT;
               end else begin
                  res_l_in = side_l_ff;
                  res_r_in = side_r_ff;
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV_LEFT: begin
            if (div_rsp.done) begin
               res_l_in          = div_rsp.quotient;
               div_req.start     = 1'b1;
               div_req.neg       = side_r_ff[SAMPLE_W-1];
               div_req.magnitude = {right_mag, 7'b0};
               state_in          = ST_DIV_RIGHT;
            end
         end
         ST_DIV_RIGHT: begin
            if (div_rsp.done) begin
               res_r_in = div_rsp.quotient;
               state_in = ST_OUT;
            end
         end
         ST_DIV_MONO: begin
            if (div_rsp.done) begin
               res_l_in = div_rsp.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the response register is free
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         side_ff       <= 1'b0;
         mute_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         side_ff       <= side_in;
         mute_count_ff <= mute_count_in;
      end
      xl_ff        <= xl_in;
      xr_ff        <= xr_in;
      code_l_ff    <= code_l_in;
      code_r_ff    <= code_r_in;
      crush_val_ff <= crush_val_in;
      num_ff       <= num_in;
      side_l_ff    <= side_l_in;
      side_r_ff    <= side_r_in;
      res_l_ff     <= res_l_in;
      res_r_ff     <= res_r_in;
      res_code_ff  <= res_code_in;
   end

   // ------------------------------------------------------------------
   // Response register: load on a free slot, drop once taken
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_left_ff  <= res_l_ff;
         rsp_right_ff <= res_r_ff;
         rsp_code_ff  <= res_code_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_left     = rsp_left_ff;
   assign rsp_chan.out_right    = rsp_right_ff;
   assign rsp_chan.crushed_code = rsp_code_ff;
endmodule

// File: rtl/core/sbc_mul.sv
// ----------------------------------------------------------------------------
// sbc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sbc_mul (
   input  logic                               clock,
   input  logic signed [sbc_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [sbc_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [sbc_pkg::MUL_P_W-1:0] product
);
   import sbc_pkg::*;

   logic signed [MUL_P_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign product = product_ff;
endmodule

// File: rtl/core/sbc_div.sv
// ----------------------------------------------------------------------------
// sbc_div
// Restoring divider, one quotient bit a cycle, sign applied at the output.
// ----------------------------------------------------------------------------
module sbc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sbc_pkg::div_req_type div_req,
   output sbc_pkg::div_rsp_type div_rsp
);
   import sbc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_QUOT_W-1:0] quo_mag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = div_req.neg;
         num_in  = div_req.magnitude;
         den_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit and subtract where it fits
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign quo_mag          = quo_ff[DIV_QUOT_W-1:0];
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? $signed(-quo_mag) : $signed(quo_mag);
endmodule

// File: rtl/core/sbc_checker.sv
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks for the stereo bit crusher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sbc_pkg::SAMPLE_W-1:0]      rsp_out_left
);
   // Reset leaves no response pending and the request side open
   `SBC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && req_ready), "reset did not clear the response or reopen the request side")

   // One request at a time: accepting closes the request side
   `SBC_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request side stayed open after an accepted request")

   // A response only appears while a request is in progress
   `SBC_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "response appeared with no request in progress")

   // A stalled response holds
   `SBC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_left)), "stalled response changed")
endmodule

bind stereo_bit_crusher sbc_checker u_sbc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_left (rsp_chan.out_left)
);

// File: tb/sv/sbc_output_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbc_output_checker
// Watches the sample and result channels of the stereo bit crusher, predicts
// each result from its own copy of the registers and the silence count, and
// compares every result field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sbc_output_checker (
   input  logic                            clock,
   input  logic                            reset,
   sbc_req_if                              req_mon,
   sbc_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [sbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   import sbc_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic [CODE_W-1:0]          code;
   } crushed_pair_type;

   localparam longint SCALE_Q26 = 64'sd67108864;
   localparam longint HALF_Q26  = 64'sd33554432;
   localparam longint SCALE_Q20 = 64'sd1048576;

   logic                 signed_mode_q;
   logic                 bypass_q;
   logic                 mono_q;
   logic [CODE_W-1:0]    invert_q;
   logic [CODE_W-1:0]    zero_q;
   logic [GAIN_W-1:0]    pre_gain_q;
   logic [GAIN_W-1:0]    post_gain_q;
   logic [GAIN_W-1:0]    blend_q;
   logic [COUNT_W-1:0]   silence_count;
   crushed_pair_type     predicted_pairs[$];
   int                   results_seen;

   function automatic longint clamp_q15(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Scale by the pre-gain, quantise to 8 bits with saturation, then mask.
   function automatic logic [CODE_W-1:0] quantise(longint x);
      longint            gain;
      longint            q;
      logic [CODE_W-1:0] code;
      gain = pre_gain_q;
      if (signed_mode_q) begin
         q = (x * gain * 255) / SCALE_Q26;
         if (q > 127) q = 127;
         if (q < -128) q = -128;
      end else begin
         q = ((x * gain + HALF_Q26) * 255) / SCALE_Q26;
         if (q > 255) q = 255;
         if (q < 0) q = 0;
      end
      code = q[CODE_W-1:0];
      return (code ^ invert_q) & ~zero_q;
   endfunction

   // Blend the crushed level with the dry sample, apply post-gain and clip.
   function automatic longint blend_side(longint x, logic [CODE_W-1:0] code);
      longint level;
      longint wet;
      longint post;
      longint num;
      wet   = blend_q;
      post  = post_gain_q;
      level = code;
      if (signed_mode_q) begin
         if (level >= 128) level = level - 256;
      end else begin
         level = level - 128;
      end
      num = wet * level * 256 + x * (1024 - wet);
      return clamp_q15((num * post) / SCALE_Q20);
   endfunction

   // Work out the result of one request; advances the silence count unless in bypass.
   function automatic crushed_pair_type crush_sample_pair(logic signed [SAMPLE_W-1:0] in_left,
                                                          logic signed [SAMPLE_W-1:0] in_right,
                                                          logic present);
      longint            xl;
      longint            xr;
      longint            ol;
      longint            orr;
      longint            mix;
      longint            count;
      longint            limit;
      logic [CODE_W-1:0] code_l;
      logic [CODE_W-1:0] code_r;
      crushed_pair_type  res;
      xl    = in_left;
      limit = SILENCE_LIMIT;
      if (present) xr = in_right;
      else xr = xl;

      if (bypass_q) begin
         res.left  = in_left;
         res.right = mono_q ? '0 : xr[SAMPLE_W-1:0];
         res.code  = '0;
         return res;
      end

      if ((magnitude(xl) <= limit && magnitude(xr) <= limit) || zero_q == ALL_BITS) begin
         if (silence_count != COUNT_MAX) silence_count = silence_count + 1'b1;
      end else begin
         silence_count = '0;
      end

      code_l = quantise(xl);
      code_r = quantise(xr);
      ol     = blend_side(xl, code_l);
      orr    = blend_side(xr, code_r);
      count  = silence_count;

      if (mono_q) begin
         if (silence_count >= FADE_START) mix = ((ol + orr) * 64) / count;
         else mix = (ol + orr) / 2;
         res.left  = mix[SAMPLE_W-1:0];
         res.right = '0;
      end else begin
         if (silence_count >= FADE_START) begin
            ol  = (ol * 128) / count;
            orr = (orr * 128) / count;
         end
         res.left  = ol[SAMPLE_W-1:0];
         res.right = orr[SAMPLE_W-1:0];
      end
      res.code = (xl == 0) ? code_r : code_l;
      return res;
   endfunction

   task automatic load_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SIGNED_MODE: signed_mode_q = data[0];
         CSR_BYPASS:      bypass_q      = data[0];
         CSR_INVERT_MASK: invert_q      = data[CODE_W-1:0];
         CSR_ZERO_MASK:   zero_q        = data[CODE_W-1:0];
         CSR_PRE_GAIN:    pre_gain_q    = data[GAIN_W-1:0];
         CSR_POST_GAIN:   post_gain_q   = data[GAIN_W-1:0];
         CSR_BLEND:       blend_q       = data[GAIN_W-1:0];
         CSR_MONO_OUTPUT: mono_q        = data[0];
         default: ;
      endcase
   endtask

   task automatic report_mismatch(bit stray, crushed_pair_type want, crushed_pair_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (stray)
            $display("result %0d with no request waiting: L=%0d R=%0d code=%02h",
                     results_seen, got.left, got.right, got.code);
         else
            $display("result %0d: expected L=%0d R=%0d code=%02h, got L=%0d R=%0d code=%02h",
                     results_seen, want.left, want.right, want.code,
                     got.left, got.right, got.code);
      end
   endtask

   always @(posedge clock) begin
      crushed_pair_type got;
      crushed_pair_type want;
      if (reset) begin
         signed_mode_q = 1'b0;
         bypass_q      = 1'b0;
         mono_q        = 1'b0;
         invert_q      = '0;
         zero_q        = '0;
         pre_gain_q    = GAIN_ONE;
         post_gain_q   = GAIN_ONE;
         blend_q       = GAIN_ONE;
         silence_count = '0;
         results_seen  = 0;
         predicted_pairs.delete();
      end else begin
         // a result here always belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.left  = rsp_mon.out_left;
            got.right = rsp_mon.out_right;
            got.code  = rsp_mon.crushed_code;
            want      = '0;
            if (predicted_pairs.size() == 0) begin
               report_mismatch(1'b1, want, got);
            end else begin
               want = predicted_pairs.pop_front();
               if (got.left !== want.left || got.right !== want.right ||
                   got.code !== want.code)
                  report_mismatch(1'b0, want, got);
            end
            results_seen++;
         end
         if (csr_we) load_register(csr_index, csr_wdata);
         if (req_mon.valid && req_mon.ready)
            predicted_pairs.push_back(crush_sample_pair(req_mon.sample_left,
                                                        req_mon.sample_right,
                                                        req_mon.right_present));
      end
      outstanding = predicted_pairs.size();
   end

endmodule

// File: tb/sv/tb_stereo_bit_crusher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_bit_crusher
// Drives sample requests and register settings into the stereo bit crusher,
// with random idling on both channels and one long result back-pressure,
// and leaves prediction and comparison to the output checker.
// ----------------------------------------------------------------------------
module tb_stereo_bit_crusher;
   import sbc_pkg::*;

   localparam int RANDOM_ITEMS     = 1850;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 100;
   localparam int CYCLE_LIMIT      = 1500000;

   typedef struct {
      logic              signed_mode;
      logic              bypass;
      logic              mono_output;
      logic [CODE_W-1:0] invert_mask;
      logic [CODE_W-1:0] zero_mask;
      logic [GAIN_W-1:0] pre_gain;
      logic [GAIN_W-1:0] post_gain;
      logic [GAIN_W-1:0] blend;
   } crusher_settings_type;

   // Amplitude profile of the requests in one phase
   typedef enum {MIX_LOUD, MIX_QUIET, MIX_SILENT} level_mix_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatches;
   int                     outstanding;
   int unsigned            cycle_count = 0;
   int unsigned            requests_sent = 0;
   bit                     quiet_phase = 1'b0;   // no idling on either side
   bit                     hold_off_due = 1'b0;  // ask the receiver for a long stall

   sbc_req_if req_if ();
   sbc_rsp_if rsp_if ();

   stereo_bit_crusher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sbc_output_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: give up if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly no gap, some short, a few long; none at all in a quiet phase.
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] boundary_sample();
      case ($urandom_range(0, 8))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return -16'sd1;
         4: return 16'sd1;
         5: return 16'sd327;
         6: return -16'sd327;
         7: return 16'sd328;
         default: return -16'sd328;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(level_mix_type mix);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_SILENT: begin
            // hold the silence window almost always so the fade kicks in
            if (roll < 99) return SAMPLE_W'(int'($urandom_range(0, 654)) - 327);
            return SAMPLE_W'($urandom);
         end
         MIX_QUIET: begin
            if (roll < 70) return SAMPLE_W'(int'($urandom_range(0, 1200)) - 600);
            if (roll < 85) return boundary_sample();
            return SAMPLE_W'($urandom);
         end
         default: begin
            if (roll < 80) return SAMPLE_W'($urandom);
            if (roll < 92) return boundary_sample();
            return SAMPLE_W'(int'($urandom_range(0, 654)) - 327);
         end
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return GAIN_ONE;
         2:       return GAIN_W'(2048);
         3:       return '1;   // above the nominal range, taken at face value
         4, 5:    return GAIN_W'($urandom_range(0, 2048));
         default: return GAIN_W'($urandom_range(512, 1536));
      endcase
   endfunction

   function automatic crusher_settings_type random_settings();
      crusher_settings_type s;
      int unsigned          roll;
      s.signed_mode = 1'($urandom_range(0, 1));
      s.bypass      = ($urandom_range(0, 5) == 0);
      s.mono_output = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       s.invert_mask = '0;
         1:       s.invert_mask = ALL_BITS;
         default: s.invert_mask = CODE_W'($urandom);
      endcase
      roll = $urandom_range(0, 9);
      if (roll < 4) s.zero_mask = '0;
      else if (roll == 4) s.zero_mask = ALL_BITS;
      else s.zero_mask = CODE_W'($urandom);
      s.pre_gain  = pick_gain();
      s.post_gain = pick_gain();
      s.blend     = pick_gain();
      return s;
   endfunction

   // Drop valid and wait for every outstanding result to come back.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
   endtask

   // Write all registers while the block is idle; unused upper bits of the
   // narrow registers sometimes carry junk, which must be ignored.
   task automatic apply_settings(crusher_settings_type s);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      wait_idle();
      write_reg(CSR_SIGNED_MODE, {junk[CSR_DATA_W-1:1], s.signed_mode});
      write_reg(CSR_BYPASS,      {junk[CSR_DATA_W-1:1], s.bypass});
      write_reg(CSR_INVERT_MASK, {junk[CSR_DATA_W-1:CODE_W], s.invert_mask});
      write_reg(CSR_ZERO_MASK,   {junk[CSR_DATA_W-1:CODE_W], s.zero_mask});
      write_reg(CSR_PRE_GAIN,    s.pre_gain);
      write_reg(CSR_POST_GAIN,   s.post_gain);
      write_reg(CSR_BLEND,       s.blend);
      write_reg(CSR_MONO_OUTPUT, {junk[CSR_DATA_W-1:1], s.mono_output});
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Offer one request after a random gap and hold it until accepted.
   task automatic send_pair(logic signed [SAMPLE_W-1:0] left,
                            logic signed [SAMPLE_W-1:0] right,
                            logic present);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid         = 1'b0;
         req_if.sample_left   = SAMPLE_W'($urandom);
         req_if.sample_right  = SAMPLE_W'($urandom);
         req_if.right_present = 1'($urandom_range(0, 1));
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid         = 1'b1;
      req_if.sample_left   = left;
      req_if.sample_right  = right;
      req_if.right_present = present;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
   endtask

   // Mono requests still carry a random right sample, which must be ignored.
   task automatic send_random(level_mix_type mix);
      send_pair(pick_sample(mix), pick_sample(mix), $urandom_range(0, 3) != 0);
   endtask

   // Result side: random stalls, plus the long hold-off when asked for it,
   // counted here while the sender keeps offering requests.
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
         end
      end
   end

   initial begin
      crusher_settings_type s;
      level_mix_type        mix;
      int unsigned          phase_len;
      int unsigned          random_start;

      req_if.valid         = 1'b0;
      req_if.sample_left   = '0;
      req_if.sample_right  = '0;
      req_if.right_present = 1'b0;
      csr_we               = 1'b0;
      csr_index            = CSR_SIGNED_MODE;
      csr_wdata            = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, full-scale and silence-edge samples,
      // left zero so the code comes from the right, mono input.
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sd327, -16'sd327, 1'b1);
      send_pair(-16'sd328, 16'sd0, 1'b1);
      send_pair(16'sd0, 16'sd12000, 1'b1);
      send_pair(-16'sd20000, 16'sh1234, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b0);

      // Signed code, pre-gain beyond range so codes saturate, mono mix
      s.signed_mode = 1'b1;  s.bypass = 1'b0;     s.mono_output = 1'b1;
      s.invert_mask = 8'hA5; s.zero_mask = 8'h0F;
      s.pre_gain    = '1;    s.post_gain = 12'd2048; s.blend = '0;
      apply_settings(s);
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sd0, -16'sd5000, 1'b1);
      send_pair(16'sd5000, 16'sd0, 1'b0);

      // Offset code, every gain at face value above 1.0, negative dry weight
      s.signed_mode = 1'b0;  s.mono_output = 1'b0;
      s.invert_mask = ALL_BITS; s.zero_mask = '0;
      s.pre_gain    = '1;    s.post_gain = '1;    s.blend = '1;
      apply_settings(s);
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(16'sd100, -16'sd100, 1'b1);
      send_pair(16'sh8000, 16'sd0, 1'b0);

      // Bypass, stereo then mono output
      s.bypass = 1'b1;
      apply_settings(s);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(-16'sd1234, 16'sh5555, 1'b0);
      s.mono_output = 1'b1;
      apply_settings(s);
      send_pair(16'sh7FFF, -16'sd1, 1'b1);
      send_pair(16'sd4321, 16'shAAAA, 1'b1);

      // All code bits zeroed counts as silence even for loud samples
      s.bypass = 1'b0; s.mono_output = 1'b0; s.zero_mask = ALL_BITS;
      s.pre_gain = GAIN_ONE; s.post_gain = GAIN_ONE; s.blend = 12'd512;
      apply_settings(s);
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(-16'sd30000, 16'sd30000, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b0);

      random_start = requests_sent;

      // Low extremes; stall the result side for a long stretch meanwhile
      s.signed_mode = 1'b0; s.bypass = 1'b0; s.mono_output = 1'b0;
      s.invert_mask = '0;   s.zero_mask = '0;
      s.pre_gain    = '0;   s.post_gain = '0; s.blend = '0;
      apply_settings(s);
      hold_off_due = 1'b1;
      repeat (60) send_random(MIX_LOUD);

      // High extremes
      s.signed_mode = 1'b1; s.mono_output = 1'b1;
      s.invert_mask = ALL_BITS; s.zero_mask = ALL_BITS;
      s.pre_gain    = '1;   s.post_gain = '1; s.blend = '1;
      apply_settings(s);
      repeat (40) send_random(MIX_QUIET);

      // Random phases; silent ones run long enough to reach the fade
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         s = random_settings();
         case ($urandom_range(0, 9))
            0, 1:    mix = MIX_SILENT;
            2, 3:    mix = MIX_QUIET;
            default: mix = MIX_LOUD;
         endcase
         if (mix == MIX_SILENT) begin
            s.bypass  = 1'b0;
            phase_len = $urandom_range(150, 350);
         end else begin
            phase_len = $urandom_range(30, 120);
         end
         apply_settings(s);
         quiet_phase = ($urandom_range(0, 4) == 0);
         repeat (phase_len) send_random(mix);
         quiet_phase = 1'b0;
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sbc_pkg.sv
rtl/core/sbc_req_if.sv
rtl/core/sbc_rsp_if.sv
rtl/core/sbc_mul.sv
rtl/core/sbc_div.sv
rtl/core/stereo_bit_crusher.sv
rtl/core/sbc_checker.sv
tb/sv/sbc_output_checker.sv
tb/sv/tb_stereo_bit_crusher.sv
